@@ hdl/apba_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package apba_pkg;

    localparam int MAX_PAGES  = 1024;
    localparam int WORD_BITS  = 32;
    localparam int PAGE_WORDS = (MAX_PAGES + WORD_BITS - 1) / WORD_BITS;
    localparam int PAGE_W     = $clog2(MAX_PAGES);
    localparam int CNT_W      = PAGE_W + 1;
    localparam int BIT_W      = $clog2(WORD_BITS);
    localparam int AW         = $clog2(PAGE_WORDS);

    typedef enum logic [1:0] {
        MODE_ALLOC   = 2'd0,
        MODE_CLAIM   = 2'd1,
        MODE_RELEASE = 2'd2,
        MODE_NONE    = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_NOSPACE = 2'd1,
        ST_RANGE   = 2'd2
    } t_status;

    typedef struct packed {
        logic                 we;
        logic [AW-1:0]        waddr;
        logic [WORD_BITS-1:0] wdata;
        logic [AW-1:0]        raddr;
    } t_ram_req;

    typedef struct packed {
        logic              valid;
        logic [PAGE_W-1:0] start;
        t_status           status;
    } t_res;

endpackage

`default_nettype wire

@@ hdl/apba_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none

module apba_ram (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire apba_pkg::t_ram_req            i_req,
    output logic [apba_pkg::WORD_BITS-1:0]     o_rdata
);
    import apba_pkg::*;

    logic [WORD_BITS-1:0]  mem [PAGE_WORDS];
    logic [PAGE_WORDS-1:0] r_valid;
    logic [WORD_BITS-1:0]  r_rdata;

    // words never written read as free
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_req.we) begin
            r_valid[i_req.waddr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            mem[i_req.waddr] <= i_req.wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_valid[i_req.raddr] ? mem[i_req.raddr] : '0;
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ hdl/apba_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none

module apba_ctrl (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    input  wire logic [1:0]                    i_mode,
    input  wire logic [apba_pkg::PAGE_W-1:0]   i_page_addr,
    input  wire logic [apba_pkg::CNT_W-1:0]    i_page_count,
    input  wire logic [apba_pkg::CNT_W-1:0]    i_lim,
    input  wire logic                          i_out_free,
    input  wire logic [apba_pkg::WORD_BITS-1:0] i_rdata,
    output apba_pkg::t_ram_req                 o_req,
    output apba_pkg::t_res                     o_res,
    output logic                               o_busy
);
    import apba_pkg::*;

    localparam int SUM_W = CNT_W + 2;
    localparam int LOG_W = $clog2(CNT_W);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_SRD  = 6'b000010,
        S_SCHK = 6'b000100,
        S_WRD  = 6'b001000,
        S_WMOD = 6'b010000,
        S_DONE = 6'b100000
    } t_state;

    t_state r_state, n_state;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [CNT_W-1:0]  r_size, n_size;
    logic [LOG_W-1:0]  r_log, n_log;
    logic [AW:0]       r_word, n_word;
    logic [AW:0]       r_base, n_base;
    logic [AW-1:0]     r_first, n_first;
    logic [AW-1:0]     r_last, n_last;
    logic [BIT_W-1:0]  r_lo, n_lo;
    logic [BIT_W-1:0]  r_hi, n_hi;
    logic              r_set, n_set;
    logic [PAGE_W-1:0] r_start, n_start;
    t_status           r_status, n_status;

    logic [WORD_BITS-1:0] lvl [BIT_W+1];
    logic [WORD_BITS-1:0] free_sel;
    logic [WORD_BITS-1:0] cand;
    logic [WORD_BITS-1:0] mask;
    logic [BIT_W-1:0]     hit_j;
    logic                 hit;
    logic                 fits_word;
    logic [CNT_W-1:0]     size_m1;
    logic [AW:0]          blk_words;
    logic [PAGE_W-1:0]    found_pn;
    logic [PAGE_W-1:0]    wr_pn;
    logic [CNT_W-1:0]     wr_cnt;
    logic [PAGE_W-1:0]    wr_last_page;
    logic [SUM_W-1:0]     blk_page;
    logic [SUM_W-1:0]     range_end;
    logic [LOG_W-1:0]     in_log;
    logic [BIT_W-1:0]     lo_cur, hi_cur;

    function automatic logic [LOG_W-1:0] ceil_log2(input logic [CNT_W-1:0] v);
        logic [LOG_W-1:0] l;
        l = '0;
        for (int i = CNT_W - 1; i >= 0; i--) begin
            if ((CNT_W'(1) << i) >= v) begin
                l = LOG_W'(i);
            end
        end
        return l;
    endfunction

    assign fits_word = r_log <= LOG_W'(BIT_W);
    assign size_m1   = r_size - CNT_W'(1);
    assign blk_words = (AW + 1)'(r_size >> BIT_W);
    assign blk_page  = SUM_W'({r_word, {BIT_W{1'b0}}});
    assign range_end = SUM_W'(i_page_addr) + SUM_W'(i_page_count);
    assign in_log    = ceil_log2(i_page_count);

    // free aligned sub-blocks of each power-of-two size within the word
    always_comb begin
        lvl[0] = ~i_rdata;
        for (int k = 1; k <= BIT_W; k++) begin
            for (int j = 0; j < WORD_BITS; j++) begin
                if (j + (1 << (k - 1)) < WORD_BITS) begin
                    lvl[k][j] = lvl[k-1][j] & lvl[k-1][j + (1 << (k - 1))];
                end else begin
                    lvl[k][j] = 1'b0;
                end
            end
        end
        free_sel = '0;
        for (int k = 0; k <= BIT_W; k++) begin
            if (r_log == LOG_W'(k)) begin
                free_sel = lvl[k];
            end
        end
        for (int j = 0; j < WORD_BITS; j++) begin
            cand[j] = free_sel[j]
                && ((BIT_W'(j) & size_m1[BIT_W-1:0]) == '0)
                && (blk_page + SUM_W'(j) + SUM_W'(r_size) <= SUM_W'(i_lim));
        end
        hit   = 1'b0;
        hit_j = '0;
        for (int j = WORD_BITS - 1; j >= 0; j--) begin
            if (cand[j]) begin
                hit   = 1'b1;
                hit_j = BIT_W'(j);
            end
        end
    end

    assign found_pn = fits_word ? {r_word[AW-1:0], hit_j}
                                : {r_base[AW-1:0], {BIT_W{1'b0}}};
    assign wr_pn    = (r_state == S_IDLE) ? i_page_addr : found_pn;
    assign wr_cnt   = (r_state == S_IDLE) ? i_page_count : r_count;
    assign wr_last_page = PAGE_W'(CNT_W'(wr_pn) + wr_cnt - CNT_W'(1));

    // bit range touched in the current word
    assign lo_cur = (r_word[AW-1:0] == r_first) ? r_lo : '0;
    assign hi_cur = (r_word[AW-1:0] == r_last) ? r_hi : '1;
    always_comb begin
        for (int j = 0; j < WORD_BITS; j++) begin
            mask[j] = (BIT_W'(j) >= lo_cur) && (BIT_W'(j) <= hi_cur);
        end
    end

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_size   = r_size;
        n_log    = r_log;
        n_word   = r_word;
        n_base   = r_base;
        n_first  = r_first;
        n_last   = r_last;
        n_lo     = r_lo;
        n_hi     = r_hi;
        n_set    = r_set;
        n_start  = r_start;
        n_status = r_status;

        o_req.we    = 1'b0;
        o_req.waddr = r_word[AW-1:0];
        o_req.raddr = r_word[AW-1:0];
        o_req.wdata = r_set ? (i_rdata | mask) : (i_rdata & ~mask);

        o_res.valid  = 1'b0;
        o_res.start  = r_start;
        o_res.status = r_status;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_status = ST_DONE;
                    unique case (t_mode'(i_mode))
                        MODE_ALLOC: begin
                            n_start = '0;
                            if (i_page_count == '0 || i_page_count > i_lim) begin
                                n_status = ST_RANGE;
                                n_state  = S_DONE;
                            end else begin
                                n_count = i_page_count;
                                n_log   = in_log;
                                n_size  = CNT_W'(1) << in_log;
                                n_word  = '0;
                                n_base  = '0;
                                n_set   = 1'b1;
                                n_state = S_SRD;
                            end
                        end
                        MODE_CLAIM, MODE_RELEASE: begin
                            n_start = i_page_addr;
                            if (i_page_count == '0 || range_end > SUM_W'(i_lim)) begin
                                n_status = ST_RANGE;
                                n_state  = S_DONE;
                            end else begin
                                n_set   = (t_mode'(i_mode) == MODE_CLAIM);
                                n_first = wr_pn[PAGE_W-1:BIT_W];
                                n_word  = {1'b0, wr_pn[PAGE_W-1:BIT_W]};
                                n_last  = wr_last_page[PAGE_W-1:BIT_W];
                                n_lo    = wr_pn[BIT_W-1:0];
                                n_hi    = wr_last_page[BIT_W-1:0];
                                n_state = S_WRD;
                            end
                        end
                        MODE_NONE: begin
                            n_start  = i_page_addr;
                            n_status = ST_RANGE;
                            n_state  = S_DONE;
                        end
                    endcase
                end
            end
            S_SRD: begin
                if (r_word == r_base && blk_page + SUM_W'(r_size) > SUM_W'(i_lim)) begin
                    n_start  = '0;
                    n_status = ST_NOSPACE;
                    n_state  = S_DONE;
                end else begin
                    n_state = S_SCHK;
                end
            end
            S_SCHK: begin
                if ((fits_word && hit)
                    || (!fits_word && i_rdata == '0 && r_word == r_base + blk_words - 1'b1)) begin
                    n_start = wr_pn;
                    n_first = wr_pn[PAGE_W-1:BIT_W];
                    n_word  = {1'b0, wr_pn[PAGE_W-1:BIT_W]};
                    n_last  = wr_last_page[PAGE_W-1:BIT_W];
                    n_lo    = wr_pn[BIT_W-1:0];
                    n_hi    = wr_last_page[BIT_W-1:0];
                    n_state = S_WRD;
                end else if (fits_word) begin
                    n_word  = r_word + 1'b1;
                    n_base  = r_word + 1'b1;
                    n_state = S_SRD;
                end else if (i_rdata != '0) begin
                    n_word  = r_base + blk_words;
                    n_base  = r_base + blk_words;
                    n_state = S_SRD;
                end else begin
                    n_word  = r_word + 1'b1;
                    n_state = S_SRD;
                end
            end
            S_WRD: begin
                n_state = S_WMOD;
            end
            S_WMOD: begin
                o_req.we = 1'b1;
                if (r_word[AW-1:0] == r_last) begin
                    n_state = S_DONE;
                end else begin
                    n_word  = r_word + 1'b1;
                    n_state = S_WRD;
                end
            end
            S_DONE: begin
                if (i_out_free) begin
                    o_res.valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_count  <= n_count;
        r_size   <= n_size;
        r_log    <= n_log;
        r_word   <= n_word;
        r_base   <= n_base;
        r_first  <= n_first;
        r_last   <= n_last;
        r_lo     <= n_lo;
        r_hi     <= n_hi;
        r_set    <= n_set;
        r_start  <= n_start;
        r_status <= n_status;
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

`default_nettype wire

@@ hdl/aligned_page_bitmap_allocator.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Page allocator over a 1024-page used-bit map held in a 32 x 32 memory that
// is read and written at one address per cycle. One request at a time:
// allocate finds the first free block of the count rounded up to a power of
// two, aligned to its size, below pages_in_use, and marks count pages; claim
// and release set or clear a range. Each bitmap word is read, then checked or
// written back. An allocate scans at most 32 words, plus a final read that
// finds the end of the map when nothing fits. After the accepting cycle a
// request stays busy while words are scanned, marked, set or cleared, and
// until its result is handed over; a rejected request goes straight to the
// handover. A result waits in an output register while the next request is
// accepted; a full, stalled output register keeps the block busy. The user
// must write pages_in_use only while idle; the block itself does not enforce
// this. Values above 1024 act as 1024. No clearing pass is needed after
// reset.
module aligned_page_bitmap_allocator (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic [1:0]                    i_mode,
    input  wire logic [apba_pkg::PAGE_W-1:0]   i_page_addr,
    input  wire logic [apba_pkg::CNT_W-1:0]    i_page_count,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic [apba_pkg::PAGE_W-1:0]        o_start_page,
    output logic [1:0]                         o_status,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [apba_pkg::CNT_W-1:0]    i_cfg_data
);
    import apba_pkg::*;

    logic [CNT_W-1:0]     r_pages;
    logic [CNT_W-1:0]     lim;
    logic                 r_out_valid;
    logic [PAGE_W-1:0]    r_out_start;
    t_status              r_out_status;
    logic                 out_free;
    logic                 busy;
    t_ram_req             ram_req;
    t_res                 res;
    logic [WORD_BITS-1:0] rdata;

    assign o_cfg_ready = 1'b1;
    assign lim = (r_pages > CNT_W'(MAX_PAGES)) ? CNT_W'(MAX_PAGES) : r_pages;
    assign out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pages <= CNT_W'(MAX_PAGES);
        end else if (i_cfg_valid) begin
            r_pages <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res.valid) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res.valid) begin
            r_out_start  <= res.start;
            r_out_status <= res.status;
        end
    end

    apba_ram u_ram (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (ram_req),
        .o_rdata (rdata)
    );

    apba_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_mode       (i_mode),
        .i_page_addr  (i_page_addr),
        .i_page_count (i_page_count),
        .i_lim        (lim),
        .i_out_free   (out_free),
        .i_rdata      (rdata),
        .o_req        (ram_req),
        .o_res        (res),
        .o_busy       (busy)
    );

    assign o_in_stall   = busy;
    assign o_out_valid  = r_out_valid;
    assign o_start_page = r_out_start;
    assign o_status     = r_out_status;

endmodule

`default_nettype wire

@@ hdl/apba_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none

module apba_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        o_in_stall,
    input wire logic        o_out_valid,
    input wire logic        i_out_stall,
    input wire logic [9:0]  o_start_page,
    input wire logic [1:0]  o_status
);
    import apba_pkg::*;

    // one request in flight
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input accepted while a request is still in flight");

    // a word appears only as a request finishes
    a_result_from_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result word without a request in flight");

    a_nospace_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == ST_NOSPACE |-> o_start_page == '0)
        else $error("no-space result with nonzero start page");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_start_page)
            && $stable(o_status))
        else $error("stalled result word changed");

endmodule

bind aligned_page_bitmap_allocator apba_checker u_apba_checker (.*);

`default_nettype wire
